// ===== src/size_class_slab_allocator_assert.svh =====
// Assertion macros for the slab allocator, sampled on the rising clock edge.
// Checking is held off while reset is high.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCSA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/scsa_pkg.sv =====
package scsa_pkg;

   localparam int MAX_SLABS      = 16;
   localparam int SLOTS_PER_SLAB = 8;
   localparam int HEADER_BYTES   = 24;
   localparam int MAX_CLASS_LOG  = 12;

   localparam int IDX_W    = $clog2(MAX_SLABS);
   localparam int CNT_W    = $clog2(MAX_SLABS + 1);
   localparam int SLOT_W   = $clog2(SLOTS_PER_SLAB);
   localparam int LOG_W    = 4;
   localparam int ADDR_W   = 16;
   localparam int SIZE_W   = 13;
   localparam int POOL_W   = 17;
   localparam int END_W    = POOL_W + 1;

   localparam int POOL_LIMIT = 65536;
   localparam int SIZE_LIMIT = 1 << MAX_CLASS_LOG;

   localparam logic [SLOTS_PER_SLAB-1:0] FULL_MAP = '1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_ROOM   = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]         base;
      logic [LOG_W-1:0]          cls;
      logic [SLOTS_PER_SLAB-1:0] map;
      logic                      full;
   } slab_entry_type;

   typedef struct packed {
      logic                 rd_en;
      logic [IDX_W-1:0]     rd_addr;
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      slab_entry_type       wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      status_type        status;
   } result_type;

   // Smallest power-of-two exponent covering size; size 0 counts as 1.
   function automatic logic [LOG_W-1:0] class_log(input logic [SIZE_W-1:0] size);
      logic [LOG_W-1:0] lg;
      lg = '0;
      for (int i = 0; i < MAX_CLASS_LOG; i++) begin
         if (((SIZE_W+1)'(1) << i) < {1'b0, size}) begin
            lg = LOG_W'(i + 1);
         end
      end
      return lg;
   endfunction

   // Lowest clear bit; 0 when every slot is taken.
   function automatic logic [SLOT_W-1:0] lowest_free(
      input logic [SLOTS_PER_SLAB-1:0] map);
      logic [SLOT_W-1:0] slot;
      slot = '0;
      for (int i = SLOTS_PER_SLAB - 1; i >= 0; i--) begin
         if (!map[i]) begin
            slot = SLOT_W'(i);
         end
      end
      return slot;
   endfunction

endpackage

// ===== src/scsa_slab_mem.sv =====
module scsa_slab_mem (
   input  logic                    clock,
   input  scsa_pkg::mem_req_type   mem_req,
   output scsa_pkg::slab_entry_type rd_data
);
   import scsa_pkg::*;

   slab_entry_type mem [MAX_SLABS];
   slab_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/scsa_engine.sv =====
module scsa_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [scsa_pkg::POOL_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  scsa_pkg::mode_type            req_mode,
   input  logic [scsa_pkg::SIZE_W-1:0]   req_size,
   input  logic [scsa_pkg::ADDR_W-1:0]   req_addr,
   output scsa_pkg::mem_req_type         mem_req,
   input  scsa_pkg::slab_entry_type      mem_rd_data,
   output logic                          res_valid,
   input  logic                          res_ready,
   output scsa_pkg::result_type          res
);
   import scsa_pkg::*;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [LOG_W-1:0]     lg_ff, lg_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   slab_entry_type       sel_ff, sel_in;
   logic [IDX_W-1:0]     sel_idx_ff, sel_idx_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [POOL_W-1:0]    tail_ff, tail_in;
   logic [POOL_W-1:0]    pool_ff;
   result_type           res_ff, res_in;

   logic                      issue;
   logic [SLOT_W-1:0]         slot;
   logic [SLOTS_PER_SLAB-1:0] new_map;
   logic [POOL_W-1:0]         hdr_end;
   logic [ADDR_W-1:0]         offset;
   logic [ADDR_W-1:0]         pos;
   logic [END_W-1:0]          slab_end;
   logic [END_W-1:0]          pool_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         tail_ff  <= '0;
         pool_ff  <= POOL_W'(4096);
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         tail_ff  <= tail_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         if (csr_wen) begin
            pool_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      lg_ff       <= lg_in;
      addr_ff     <= addr_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      sel_ff      <= sel_in;
      sel_idx_ff  <= sel_idx_in;
      res_ff      <= res_in;
   end

   // Datapath for the update and append steps, and the read-issue test of the scan
   always_comb begin
      slot     = lowest_free(sel_ff.map);
      new_map  = sel_ff.map | (SLOTS_PER_SLAB'(1) << slot);
      hdr_end  = {1'b0, sel_ff.base} + POOL_W'(HEADER_BYTES);
      offset   = ADDR_W'({1'b0, addr_ff} - hdr_end);
      pos      = offset >> sel_ff.cls;
      slab_end = END_W'(tail_ff) + END_W'(HEADER_BYTES)
               + (END_W'(SLOTS_PER_SLAB) << lg_ff);
      pool_eff = (pool_ff > POOL_W'(POOL_LIMIT)) ? END_W'(POOL_LIMIT) : END_W'(pool_ff);
      issue    = idx_ff < count_ff;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      lg_in       = lg_ff;
      addr_in     = addr_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      sel_in      = sel_ff;
      sel_idx_in  = sel_idx_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      tail_in     = tail_ff;
      res_in      = res_ff;
      mem_req     = '0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               lg_in    = class_log(req_size);
               addr_in  = req_addr;
               idx_in   = '0;
               found_in = 1'b0;
               if (req_mode == MODE_ALLOC && req_size > SIZE_W'(SIZE_LIMIT)) begin
                  res_in   = '{addr: '0, status: STATUS_TOO_LARGE};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         // One read issued per cycle; its data is checked in the next cycle.
         ST_SCAN: begin
            if (issue) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[IDX_W-1:0];
               idx_in          = idx_ff + CNT_W'(1);
               pend_in         = 1'b1;
               pend_idx_in     = idx_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               if (mode_ff == MODE_ALLOC) begin
                  if (mem_rd_data.cls == lg_ff && !mem_rd_data.full) begin
                     sel_in     = mem_rd_data;
                     sel_idx_in = pend_idx_ff;
                     found_in   = 1'b1;
                     pend_in    = 1'b0;
                     state_in   = ST_UPDATE;
                  end
               end else if (mem_rd_data.base <= addr_ff) begin
                  // bases ascend, so the last match is the owning slab
                  sel_in     = mem_rd_data;
                  sel_idx_in = pend_idx_ff;
                  found_in   = 1'b1;
               end
            end else if (!issue) begin
               if (mode_ff == MODE_ALLOC) begin
                  state_in = ST_APPEND;
               end else if (found_ff) begin
                  state_in = ST_UPDATE;
               end else begin
                  res_in   = '{addr: '0, status: STATUS_OK};
                  state_in = ST_DONE;
               end
            end
         end

         ST_UPDATE: begin
            mem_req.wr_addr = sel_idx_ff;
            if (mode_ff == MODE_ALLOC) begin
               mem_req.wr_en        = 1'b1;
               mem_req.wr_data      = sel_ff;
               mem_req.wr_data.map  = new_map;
               mem_req.wr_data.full = (new_map == FULL_MAP);
               res_in.addr   = sel_ff.base + ADDR_W'(HEADER_BYTES)
                             + (ADDR_W'(slot) << lg_ff);
               res_in.status = STATUS_OK;
            end else begin
               if ({1'b0, addr_ff} >= hdr_end && pos < ADDR_W'(SLOTS_PER_SLAB)) begin
                  mem_req.wr_en        = 1'b1;
                  mem_req.wr_data      = sel_ff;
                  mem_req.wr_data.map  = sel_ff.map
                                       & ~(SLOTS_PER_SLAB'(1) << pos[SLOT_W-1:0]);
                  mem_req.wr_data.full = 1'b0;
               end
               res_in = '{addr: '0, status: STATUS_OK};
            end
            state_in = ST_DONE;
         end

         ST_APPEND: begin
            if (count_ff >= CNT_W'(MAX_SLABS) || slab_end > pool_eff) begin
               res_in = '{addr: '0, status: STATUS_NO_ROOM};
            end else begin
               mem_req.wr_en        = 1'b1;
               mem_req.wr_addr      = count_ff[IDX_W-1:0];
               mem_req.wr_data.base = tail_ff[ADDR_W-1:0];
               mem_req.wr_data.cls  = lg_ff;
               mem_req.wr_data.map  = SLOTS_PER_SLAB'(1);
               mem_req.wr_data.full = (SLOTS_PER_SLAB'(1) == FULL_MAP);
               count_in             = count_ff + CNT_W'(1);
               tail_in              = slab_end[POOL_W-1:0];
               res_in.addr          = tail_ff[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
               res_in.status        = STATUS_OK;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

// ===== src/size_class_slab_allocator.sv =====
// Power-of-two size-class slab allocator over a byte pool.
// req channel: one transaction per request. tuser selects allocate (0) or
// free (1); tdata carries the requested size and the address to free.
// rsp channel: exactly one transaction per request, in request order,
// carrying the granted block address and a status code.
// csr port: a write with csr_wen sets the pool size in bytes; write only
// while no request is outstanding.
// Slab state lives in a 16-entry synchronous RAM walked one entry per cycle
// with a registered read. A request walks every slab in use, but an
// allocate that hits an early slab finishes sooner and an oversized
// allocate skips the walk. One request is in flight at a time; the next
// one is accepted in the cycle after the result moves to the output
// register.
// The result sits in an output register: a new request is accepted while it
// waits, and if rsp_tready stays low the next result is held in the engine
// until the register drains.
// Reset clears the slab count and restores the pool size to 4096 bytes;
// RAM contents are not cleared, since entries past the count are never read.
`include "size_class_slab_allocator_assert.svh"

module size_class_slab_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [16:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [12:0] request_size, [28:13] release_address
   input  logic [0:0]  req_tuser,  // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // [15:0] block_address, [17:16] status
);
   import scsa_pkg::*;

   mem_req_type    mem_req;
   slab_entry_type mem_rd_data;
   logic           res_valid;
   logic           res_ready;
   result_type     res;

   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_data_ff, rsp_data_in;

   scsa_slab_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   scsa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (mode_type'(req_tuser[0])),
      .req_size    (req_tdata[SIZE_W-1:0]),
      .req_addr    (req_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   always_comb begin
      res_ready    = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = (res_valid && res_ready) ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.status, rsp_data_ff.addr};

   `SCSA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready,
      "engine still ready after accepting a request")
   `SCSA_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, rsp_tvalid,
      "handed-off result did not reach the output register")
   `SCSA_ASSERT_SAME(a_fail_addr_zero, res_valid && res.status != STATUS_OK,
      res.addr == '0, "failed allocate carries a nonzero address")
   `SCSA_ASSERT_SAME(a_no_write_on_result, res_valid, !mem_req.wr_en,
      "slab RAM written while a result is pending")

endmodule
